### rtl/core/assert_macros.svh
// assertion macros shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CBI_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cbi_pkg.sv
package cbi_pkg;

    localparam int INDEX_W  = 5;
    localparam int SAMPLE_W = 32;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [INDEX_W-1:0]  idx;
        logic [SAMPLE_W-1:0] data;
        logic                oor;
    } cmd_t;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;

    localparam int DIV_DVD_W = 64;
    localparam int DIV_DSR_W = 33;
    localparam int DIV_CNT_W = 7;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] qbits;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;

    localparam int INNER_SHIFT = 25;
    localparam int END_SHIFT   = 24;

    localparam longint TAYLOR_DIV [12] = '{
        Q30_ONE * 2,   Q30_ONE * 12,  Q30_ONE * 30,  Q30_ONE * 56,
        Q30_ONE * 90,  Q30_ONE * 132, Q30_ONE * 182, Q30_ONE * 240,
        Q30_ONE * 306, Q30_ONE * 380, Q30_ONE * 462, Q30_ONE * 552
    };

endpackage

### rtl/core/chebyshev_barycentric_interpolator.sv
// channel   | handshake         | payload
// ----------+-------------------+---------------------------------------------------
// input     | s_valid / s_ready | s_mode, s_node_index, s_sample_value, s_query_point
// result    | m_valid / m_ready | m_interpolated_value, m_out_of_range, m_saturated
//
// load: written to the sample memory as the back end pops it, no result
// query: uses the one-bit-per-cycle divider, shared by the per-node reciprocals
//   and the final quotient
// node hit: the stored sample is returned with no divide; a four-deep request queue lets the input run ahead
// reset: synchronous, samples read as zero until loaded, no clearing pass
module chebyshev_barycentric_interpolator #(
    parameter int NODE_COUNT_MINUS_ONE = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [4:0]          s_node_index,
    input  logic signed [31:0]  s_sample_value,
    input  logic signed [31:0]  s_query_point,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_interpolated_value,
    output logic                m_out_of_range,
    output logic                m_saturated
);

    logic              push;
    cbi_pkg::cmd_t     push_data;
    logic              pop;
    cbi_pkg::cmd_t     pop_data;
    logic              full;
    logic              empty;
    cbi_pkg::div_req_t div_req;
    cbi_pkg::div_rsp_t div_rsp;

    cbi_front #(
        .NODE_COUNT_MINUS_ONE(NODE_COUNT_MINUS_ONE)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_node_index   (s_node_index),
        .s_sample_value (s_sample_value),
        .s_query_point  (s_query_point),
        .fifo_full      (full),
        .push           (push),
        .push_data      (push_data)
    );

    cbi_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    cbi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    cbi_back #(
        .NODE_COUNT_MINUS_ONE(NODE_COUNT_MINUS_ONE)
    ) u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (pop_data),
        .cmd_empty            (empty),
        .cmd_pop              (pop),
        .div_req              (div_req),
        .div_rsp              (div_rsp),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_interpolated_value (m_interpolated_value),
        .m_out_of_range       (m_out_of_range),
        .m_saturated          (m_saturated)
    );

endmodule

### rtl/core/cbi_front.sv
module cbi_front #(
    parameter int NODE_COUNT_MINUS_ONE = 16
) (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [cbi_pkg::INDEX_W-1:0]       s_node_index,
    input  logic signed [cbi_pkg::SAMPLE_W-1:0] s_sample_value,
    input  logic signed [31:0]                s_query_point,
    input  logic                              fifo_full,
    output logic                              push,
    output cbi_pkg::cmd_t                     push_data
);

    logic is_query;
    logic idx_ok;

    assign is_query = (cbi_pkg::op_t'(s_mode) == cbi_pkg::OP_QUERY);
    assign idx_ok   = (32'(s_node_index) <= 32'(NODE_COUNT_MINUS_ONE));
    assign s_ready  = !fifo_full;

    // loads past the last node are dropped here
    assign push = s_valid && s_ready && (is_query || idx_ok);

    always_comb begin
        push_data.op   = cbi_pkg::op_t'(s_mode);
        push_data.idx  = s_node_index;
        push_data.data = is_query ? s_query_point : s_sample_value;
        push_data.oor  = is_query &&
                         ((s_query_point > 32'sd1073741824) ||
                          (s_query_point < -32'sd1073741824));
    end

endmodule

### rtl/core/cbi_fifo.sv
`include "assert_macros.svh"

module cbi_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cbi_pkg::cmd_t push_data,
    input  logic          pop,
    output cbi_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);

    cbi_pkg::cmd_t                  mem [cbi_pkg::CMD_DEPTH];
    logic [cbi_pkg::CMD_PTR_W-1:0]  wr_ptr_reg;
    logic [cbi_pkg::CMD_PTR_W-1:0]  rd_ptr_reg;
    logic [cbi_pkg::CMD_PTR_W:0]    count_reg;

    assign full     = (count_reg == (cbi_pkg::CMD_PTR_W+1)'(cbi_pkg::CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `CBI_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, !full || pop, "queue overflow")
    `CBI_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count lost a request")

endmodule

### rtl/core/cbi_div.sv
module cbi_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cbi_pkg::div_req_t req,
    output cbi_pkg::div_rsp_t rsp
);

    localparam logic [cbi_pkg::DIV_CNT_W-1:0] CNT_FULL =
        cbi_pkg::DIV_CNT_W'(cbi_pkg::DIV_DVD_W);

    logic                             busy_reg;
    logic                             done_reg;
    logic [cbi_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [cbi_pkg::DIV_DSR_W-1:0]    rem_reg;
    logic [cbi_pkg::DIV_DSR_W-1:0]    dsr_reg;
    logic [cbi_pkg::DIV_DVD_W-1:0]    sh_reg;
    logic [cbi_pkg::DIV_DVD_W-1:0]    quo_reg;
    logic [cbi_pkg::DIV_DSR_W:0]      rem_next;
    logic [cbi_pkg::DIV_DSR_W:0]      diff;
    logic                             ge;

    always_comb begin
        rem_next = {rem_reg, sh_reg[cbi_pkg::DIV_DVD_W-1]};
        diff     = rem_next - {1'b0, dsr_reg};
        ge       = (rem_next >= {1'b0, dsr_reg});
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                // leading part of the dividend is known to sit below the divisor
                busy_reg <= 1'b1;
                cnt_reg  <= req.qbits;
                rem_reg  <= cbi_pkg::DIV_DSR_W'(req.dividend >> req.qbits);
                sh_reg   <= req.dividend << (CNT_FULL - req.qbits);
                dsr_reg  <= req.divisor;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[cbi_pkg::DIV_DSR_W-1:0]
                               : rem_next[cbi_pkg::DIV_DSR_W-1:0];
                sh_reg   <= {sh_reg[cbi_pkg::DIV_DVD_W-2:0], 1'b0};
                quo_reg  <= {quo_reg[cbi_pkg::DIV_DVD_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == cbi_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/cbi_back.sv
`include "assert_macros.svh"

module cbi_back #(
    parameter int NODE_COUNT_MINUS_ONE = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cbi_pkg::cmd_t        cmd,
    input  logic                 cmd_empty,
    output logic                 cmd_pop,
    output cbi_pkg::div_req_t    div_req,
    input  cbi_pkg::div_rsp_t    div_rsp,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_interpolated_value,
    output logic                 m_out_of_range,
    output logic                 m_saturated
);

    localparam int NODE_TOTAL = NODE_COUNT_MINUS_ONE + 1;
    localparam int IDX_W      = $clog2(NODE_TOTAL);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT_MINUS_ONE);

    typedef logic signed [31:0] node_arr_t [NODE_TOTAL];

    function automatic node_arr_t build_nodes();
        node_arr_t tab;
        longint    x;
        longint    x2;
        longint    term;
        longint    sum;
        longint    jc;
        for (int j = 0; j < NODE_TOTAL; j++) begin
            jc = (2 * j < NODE_COUNT_MINUS_ONE) ? longint'(j)
                                                : longint'(NODE_COUNT_MINUS_ONE - j);
            x    = cbi_pkg::PI_Q30 * jc / NODE_COUNT_MINUS_ONE;
            x2   = x * x / cbi_pkg::Q30_ONE;
            term = cbi_pkg::Q30_ONE;
            sum  = cbi_pkg::Q30_ONE;
            for (int k = 0; k < 12; k++) begin
                term = -(term * x2) / cbi_pkg::TAYLOR_DIV[k];
                sum  = sum + term;
            end
            if (2 * j == NODE_COUNT_MINUS_ONE) begin
                tab[j] = '0;
            end else if (2 * j < NODE_COUNT_MINUS_ONE) begin
                tab[j] = 32'(sum);
            end else begin
                tab[j] = 32'(-sum);
            end
        end
        return tab;
    endfunction

    localparam node_arr_t NODE_TAB = build_nodes();

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_HIT_OUT,
        ST_RSTART,
        ST_RWAIT,
        ST_MUL,
        ST_ACC,
        ST_FSTART,
        ST_FWAIT,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       j_reg;
    logic signed [31:0]     t_reg;
    logic                   oor_reg;
    logic [31:0]            m_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic signed [26:0]     r_reg;
    logic signed [58:0]     prod_reg;
    logic signed [63:0]     num_reg;
    logic signed [33:0]     den_reg;
    logic signed [31:0]     res_val_reg;
    logic                   res_sat_reg;
    logic                   m_valid_reg;
    logic signed [31:0]     m_value_reg;
    logic                   m_oor_reg;
    logic                   m_sat_reg;

    logic signed [31:0]     sample_mem [NODE_TOTAL];
    logic [NODE_TOTAL-1:0]  sample_vld_reg;
    logic signed [31:0]     rdata_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;

    logic signed [31:0]     node_j;
    logic signed [32:0]     d_cur;
    logic [31:0]            a_cur;
    logic                   end_node;
    logic [63:0]            num_abs;
    logic [32:0]            den_abs;
    logic [25:0]            rq;
    logic                   r_neg;
    logic signed [26:0]     r_val;
    logic [63:0]            fq;
    logic                   f_neg;
    logic signed [31:0]     f_val;
    logic                   f_sat;

    always_comb begin
        node_j   = NODE_TAB[j_reg];
        d_cur    = 33'(t_reg) - 33'(node_j);
        a_cur    = d_cur[32] ? 32'(-d_cur) : d_cur[31:0];
        end_node = (j_reg == '0) || (j_reg == LAST_IDX);
        num_abs  = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
        den_abs  = den_reg[33] ? 33'(-den_reg) : den_reg[32:0];
        rq       = div_rsp.quotient[25:0];
        r_neg    = d_cur[32] ^ j_reg[0];
        r_val    = r_neg ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
        fq       = div_rsp.quotient;
        f_neg    = num_reg[63] ^ den_reg[33];
        if (!f_neg && (fq > 64'd2147483647)) begin
            f_val = 32'sh7fffffff;
            f_sat = 1'b1;
        end else if (f_neg && (fq > 64'd2147483648)) begin
            f_val = 32'sh80000000;
            f_sat = 1'b1;
        end else begin
            f_val = f_neg ? 32'(-fq) : fq[31:0];
            f_sat = 1'b0;
        end
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.qbits    = cbi_pkg::DIV_CNT_W'(cbi_pkg::INNER_SHIFT + 1);
        div_req.dividend = 64'(m_reg) << cbi_pkg::INNER_SHIFT;
        div_req.divisor  = 33'(a_cur);
        case (state_reg)
            ST_RSTART: begin
                div_req.start = 1'b1;
                if (end_node) begin
                    div_req.qbits    = cbi_pkg::DIV_CNT_W'(cbi_pkg::END_SHIFT + 1);
                    div_req.dividend = 64'(m_reg) << cbi_pkg::END_SHIFT;
                end
            end
            ST_FSTART: begin
                div_req.start    = (den_reg != '0);
                div_req.qbits    = cbi_pkg::DIV_CNT_W'(cbi_pkg::DIV_DVD_W);
                div_req.dividend = num_abs;
                div_req.divisor  = den_abs;
            end
            default: begin
            end
        endcase
    end

    assign cmd_pop = (state_reg == ST_IDLE) && !cmd_empty;
    assign wr_en   = cmd_pop && (cmd.op == cbi_pkg::OP_LOAD);
    assign wr_addr = IDX_W'(cmd.idx);
    assign rd_addr = (state_reg == ST_HIT) ? hit_idx_reg : j_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sample_mem[wr_addr] <= cmd.data;
        end
        rdata_reg <= sample_vld_reg[rd_addr] ? sample_mem[rd_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_vld_reg <= '0;
        end else if (wr_en) begin
            sample_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_pop && (cmd.op == cbi_pkg::OP_QUERY)) begin
                        t_reg     <= cmd.data;
                        oor_reg   <= cmd.oor;
                        j_reg     <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if ((j_reg == '0) || (a_cur < m_reg)) begin
                        m_reg <= a_cur;
                    end
                    if ((d_cur == '0) && !hit_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= j_reg;
                    end
                    if (j_reg == LAST_IDX) begin
                        if (hit_reg || (d_cur == '0)) begin
                            state_reg <= ST_HIT;
                        end else begin
                            j_reg     <= '0;
                            num_reg   <= '0;
                            den_reg   <= '0;
                            state_reg <= ST_RSTART;
                        end
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_HIT: begin
                    state_reg <= ST_HIT_OUT;
                end
                ST_HIT_OUT: begin
                    res_val_reg <= rdata_reg;
                    res_sat_reg <= 1'b0;
                    state_reg   <= ST_DONE;
                end
                ST_RSTART: begin
                    state_reg <= ST_RWAIT;
                end
                ST_RWAIT: begin
                    if (div_rsp.done) begin
                        r_reg     <= r_val;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= 59'(r_reg) * 59'(rdata_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    num_reg <= num_reg + 64'(prod_reg);
                    den_reg <= den_reg + 34'(r_reg);
                    if (j_reg == LAST_IDX) begin
                        state_reg <= ST_FSTART;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_RSTART;
                    end
                end
                ST_FSTART: begin
                    if (den_reg == '0) begin
                        res_val_reg <= '0;
                        res_sat_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end else begin
                        state_reg <= ST_FWAIT;
                    end
                end
                ST_FWAIT: begin
                    if (div_rsp.done) begin
                        res_val_reg <= f_val;
                        res_sat_reg <= f_sat;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= res_val_reg;
                        m_oor_reg   <= oor_reg;
                        m_sat_reg   <= res_sat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_interpolated_value = m_value_reg;
    assign m_out_of_range       = m_oor_reg;
    assign m_saturated          = m_sat_reg;

    `CBI_ASSERT_IMP(a_div_free, aclk, aresetn, div_req.start, !div_rsp.busy,
        "divider started while busy")
    `CBI_ASSERT_IMP(a_sat_extreme, aclk, aresetn, m_valid_reg && m_sat_reg,
        (m_value_reg == 32'sh7fffffff) || (m_value_reg == 32'sh80000000),
        "saturated result not at a limit")
    `CBI_ASSERT_IMP(a_result_from_done, aclk, aresetn, $rose(m_valid_reg),
        $past(state_reg) == ST_DONE, "result raised outside the finish step")

endmodule

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES_N    = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int RAND_ITEMS = 1150;
    localparam int DRAIN      = 700;

    typedef struct {
        logic signed [31:0] value;
        logic               oor;
        logic               sat;
    } interp_result_t;

    class interp_scoreboard;
        longint node_pos [NODES_N+1];
        longint samples [NODES_N+1];
        interp_result_t pending [$];
        int errors;
        int queries;
        int loads;

        function new();
            longint x, x2, term, sum;
            for (int j = 0; j <= NODES_N; j++) begin
                samples[j] = 0;
            end
            for (int j = 0; j <= NODES_N; j++) begin
                if (2 * j == NODES_N) begin
                    node_pos[j] = 0;
                end else begin
                    x = cbi_pkg::PI_Q30 * longint'((2 * j < NODES_N) ? j : NODES_N - j)
                        / NODES_N;
                    x2 = (x * x) / cbi_pkg::Q30_ONE;
                    term = cbi_pkg::Q30_ONE;
                    sum = cbi_pkg::Q30_ONE;
                    for (int k = 1; k <= 12; k++) begin
                        term = -(term * x2) / (cbi_pkg::Q30_ONE * (2 * k - 1) * (2 * k));
                        sum += term;
                    end
                    node_pos[j] = (2 * j < NODES_N) ? sum : -sum;
                end
            end
        endfunction

        function void note(cbi_pkg::op_t op, logic [4:0] idx, logic signed [31:0] smp,
                           logic signed [31:0] q);
            interp_result_t e;
            longint t, m, d, a, r, num, den, val;
            if (op == cbi_pkg::OP_LOAD) begin
                loads++;
                if (idx <= NODES_N) samples[idx] = smp;
                return;
            end
            queries++;
            t = q;
            e.oor = (t > cbi_pkg::Q30_ONE) || (t < -cbi_pkg::Q30_ONE);
            e.sat = 1'b0;
            m = -1;
            for (int j = 0; j <= NODES_N; j++) begin
                d = t - node_pos[j];
                a = (d < 0) ? -d : d;
                if (m < 0 || a < m) m = a;
            end
            val = 0;
            if (m == 0) begin
                for (int j = NODES_N; j >= 0; j--) begin
                    if (t == node_pos[j]) val = samples[j];
                end
            end else begin
                num = 0;
                den = 0;
                for (int j = 0; j <= NODES_N; j++) begin
                    d = t - node_pos[j];
                    r = (m << ((j == 0 || j == NODES_N) ? cbi_pkg::END_SHIFT
                                                        : cbi_pkg::INNER_SHIFT)) / d;
                    if (j % 2 == 1) r = -r;
                    num += r * samples[j];
                    den += r;
                end
                if (den != 0) begin
                    val = num / den;
                    if (val > 64'sd2147483647) begin
                        val = 64'sd2147483647;
                        e.sat = 1'b1;
                    end else if (val < -64'sd2147483648) begin
                        val = -64'sd2147483648;
                        e.sat = 1'b1;
                    end
                end
            end
            e.value = val[31:0];
            pending.insert(pending.size(), e);
        endfunction

        function void check(logic signed [31:0] value, logic oor, logic sat);
            interp_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result value=%0d", value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                $error("interpolated_value expected %0d actual %0d", e.value, value);
                errors++;
            end
            if (oor !== e.oor) begin
                $error("out_of_range expected %0b actual %0b", e.oor, oor);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated expected %0b actual %0b", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = 1'b0;
    logic [4:0]         s_node_index = '0;
    logic signed [31:0] s_sample_value = '0;
    logic signed [31:0] s_query_point = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_interpolated_value;
    logic               m_out_of_range;
    logic               m_saturated;

    int send_idle = 30;
    int recv_idle = 50;
    int quiet_cycles = 0;
    interp_scoreboard sb = new();

    chebyshev_barycentric_interpolator #(.NODE_COUNT_MINUS_ONE(NODES_N)) u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sb.note(cbi_pkg::op_t'(s_mode), s_node_index, s_sample_value, s_query_point);
        end
        if (m_valid && m_ready) begin
            sb.check(m_interpolated_value, m_out_of_range, m_saturated);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(cbi_pkg::op_t op, logic [4:0] idx, logic [31:0] smp,
                                logic [31:0] q);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode = op;
        s_node_index = idx;
        s_sample_value = smp;
        s_query_point = q;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic random_request();
        logic [31:0] q;
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            send_request(cbi_pkg::OP_LOAD,
                         (pick < 45) ? 5'($urandom_range(NODES_N)) : 5'($urandom),
                         (pick % 4 == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 22))
                         - (1 << 21)), '0);
        end else begin
            if (pick < 80) q = 32'($urandom_range(0, 1 << 31) - (1 << 30));
            else if (pick < 88) q = 32'(sb.node_pos[$urandom_range(NODES_N)]
                                   + $urandom_range(2) - 1);
            else q = $urandom;
            send_request(cbi_pkg::OP_QUERY, 5'($urandom), $urandom, q);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_request(cbi_pkg::OP_QUERY, '0, '0, 32'sd12345);
        for (int j = 0; j <= NODES_N; j++) begin
            send_request(cbi_pkg::OP_LOAD, 5'(j), (j % 2) ? 32'h8000_0000 : 32'h7fff_ffff,
                         '0);
        end
        send_request(cbi_pkg::OP_LOAD, 5'd17, 32'h1234_5678, '0);
        send_request(cbi_pkg::OP_LOAD, 5'd31, 32'hffff_ffff, '0);
        send_request(cbi_pkg::OP_QUERY, '0, '0, 32'h4000_0000);
        send_request(cbi_pkg::OP_QUERY, '0, '0, 32'hc000_0000);
        send_request(cbi_pkg::OP_QUERY, '0, '0, 32'h0000_0000);
        send_request(cbi_pkg::OP_QUERY, '0, '0, 32'(sb.node_pos[3] + 1));
        send_request(cbi_pkg::OP_QUERY, '0, '0, 32'h7fff_ffff);
        send_request(cbi_pkg::OP_QUERY, '0, '0, 32'h8000_0000);
        send_request(cbi_pkg::OP_QUERY, 5'h1f, 32'hffff_ffff, 32'h3fff_0000);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 3) begin
                send_idle = 50;
                recv_idle = 30;
            end else if (i == 2 * RAND_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_request();
        end
        s_valid = 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("loaded %0d samples and checked %0d queries, node hits and out-of-range",
                 sb.loads, sb.queries);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cbi_pkg.sv
rtl/core/cbi_front.sv
rtl/core/cbi_fifo.sv
rtl/core/cbi_div.sv
rtl/core/cbi_back.sv
rtl/core/chebyshev_barycentric_interpolator.sv
bench/testbench.sv
